@@ rtl/tbba_pkg.sv @@
// Shared types and constants for the transformed box bounds accumulator.
package tbba_pkg;

    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int ROW_COUNT = 3;
    localparam int AXIS_COUNT = 3;
    localparam int COEF_COUNT = 4;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_ADD   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ADD
    } op_t;

    typedef struct packed {
        logic load_b;
        logic load_c;
    } pipe_ctl_t;

endpackage

@@ rtl/tbba_row_span.sv @@
// One matrix row: corner products, extreme sums, floor and saturation.
module tbba_row_span
    import tbba_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  pipe_ctl_t ctl,
    input  word_t     coef [COEF_COUNT],
    input  word_t     box_lo [AXIS_COUNT],
    input  word_t     box_hi [AXIS_COUNT],
    output word_t     low_coord,
    output word_t     high_coord
);

    localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (WORD_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (WORD_W - 1));

    logic signed [PROD_W-1:0] prod_lo_reg [AXIS_COUNT];
    logic signed [PROD_W-1:0] prod_hi_reg [AXIS_COUNT];
    word_t                    trans_reg;
    logic signed [SUM_W-1:0]  sum_low_reg;
    logic signed [SUM_W-1:0]  sum_high_reg;
    logic signed [SUM_W-1:0]  sum_low_next;
    logic signed [SUM_W-1:0]  sum_high_next;

    function automatic word_t floor_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] f;
        f = v >>> FRAC_BITS;
        if (f > SAT_HI) begin
            return word_t'(SAT_HI[WORD_W-1:0]);
        end
        if (f < SAT_LO) begin
            return word_t'(SAT_LO[WORD_W-1:0]);
        end
        return word_t'(f[WORD_W-1:0]);
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctl.load_b)
        begin
            for (int k = 0; k < AXIS_COUNT; k++)
            begin
                prod_lo_reg[k] <= PROD_W'(coef[k]) * PROD_W'(box_lo[k]);
                prod_hi_reg[k] <= PROD_W'(coef[k]) * PROD_W'(box_hi[k]);
            end
            trans_reg <= coef[COEF_COUNT-1];
        end
    end

    // The floor and saturation are monotonic, so the extreme corner on this axis
    // is the sum of the smaller (or larger) product of each coordinate pair.
    always_comb
    begin
        sum_low_next  = SUM_W'(trans_reg) <<< FRAC_BITS;
        sum_high_next = SUM_W'(trans_reg) <<< FRAC_BITS;
        for (int k = 0; k < AXIS_COUNT; k++)
        begin
            if (prod_lo_reg[k] < prod_hi_reg[k])
            begin
                sum_low_next  = sum_low_next + SUM_W'(prod_lo_reg[k]);
                sum_high_next = sum_high_next + SUM_W'(prod_hi_reg[k]);
            end
            else
            begin
                sum_low_next  = sum_low_next + SUM_W'(prod_hi_reg[k]);
                sum_high_next = sum_high_next + SUM_W'(prod_lo_reg[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_c)
        begin
            sum_low_reg  <= sum_low_next;
            sum_high_reg <= sum_high_next;
        end
    end

    assign low_coord  = floor_sat(sum_low_reg);
    assign high_coord = floor_sat(sum_high_reg);

endmodule

@@ rtl/transformed_box_bounds_accumulator.sv @@
// Each beat moves through the input, product, sum and bounds stage registers in turn.
// Throughput: one beat per cycle while result_stall is low.
// While a result beat waits, up to three more beats are accepted before the input stalls.
// Reset clears the matrix, the bounds and every stage valid bit asynchronously.
// The bounds register is the result register and shows the state after each beat.
module transformed_box_bounds_accumulator
    import tbba_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  cmd,
    input  logic [1:0]  row_index,
    input  word_t       word_0,
    input  word_t       word_1,
    input  word_t       word_2,
    input  word_t       word_3,
    input  word_t       word_4,
    input  word_t       word_5,
    input  logic        box_valid,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        bounds_valid,
    output word_t       low_x,
    output word_t       low_y,
    output word_t       low_z,
    output word_t       high_x,
    output word_t       high_y,
    output word_t       high_z
);

    word_t     matrix_reg [ROW_COUNT][COEF_COUNT];
    word_t     box_lo_a_reg [AXIS_COUNT];
    word_t     box_hi_a_reg [AXIS_COUNT];
    op_t       op_a_reg;
    op_t       op_b_reg;
    op_t       op_c_reg;
    op_t       op_in;
    logic      a_valid_reg;
    logic      b_valid_reg;
    logic      c_valid_reg;
    logic      o_valid_reg;
    logic      accept;
    logic      load_o;
    logic      a_free;
    logic      b_free;
    logic      c_free;
    pipe_ctl_t ctl;
    word_t     low_coord [ROW_COUNT];
    word_t     high_coord [ROW_COUNT];
    word_t     bound_low_reg [AXIS_COUNT];
    word_t     bound_high_reg [AXIS_COUNT];
    word_t     bound_low_next [AXIS_COUNT];
    word_t     bound_high_next [AXIS_COUNT];
    logic      have_point_reg;
    logic      have_point_next;

    assign load_o     = c_valid_reg && (!o_valid_reg || !result_stall);
    assign c_free     = !c_valid_reg || load_o;
    assign ctl.load_c = b_valid_reg && c_free;
    assign b_free     = !b_valid_reg || ctl.load_c;
    assign ctl.load_b = a_valid_reg && b_free;
    assign a_free     = !a_valid_reg || ctl.load_b;
    assign item_stall = !a_free;
    assign accept     = item_valid && a_free;

    always_comb
    begin
        case (cmd)
            CMD_CLEAR: op_in = OP_CLEAR;
            CMD_ADD:   op_in = box_valid ? OP_ADD : OP_NONE;
            default:   op_in = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            op_a_reg    <= OP_NONE;
            op_b_reg    <= OP_NONE;
            op_c_reg    <= OP_NONE;
        end
        else
        begin
            if (accept)
            begin
                a_valid_reg <= 1'b1;
                op_a_reg    <= op_in;
            end
            else if (ctl.load_b)
            begin
                a_valid_reg <= 1'b0;
            end
            if (ctl.load_b)
            begin
                b_valid_reg <= 1'b1;
                op_b_reg    <= op_a_reg;
            end
            else if (ctl.load_c)
            begin
                b_valid_reg <= 1'b0;
            end
            if (ctl.load_c)
            begin
                c_valid_reg <= 1'b1;
                op_c_reg    <= op_b_reg;
            end
            else if (load_o)
            begin
                c_valid_reg <= 1'b0;
            end
            if (load_o)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // A row load takes effect at acceptance; only later beats read the matrix.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                for (int k = 0; k < COEF_COUNT; k++)
                begin
                    matrix_reg[r][k] <= '0;
                end
            end
        end
        else if (accept && (cmd == CMD_LOAD) && (int'(row_index) < ROW_COUNT))
        begin
            matrix_reg[row_index][0] <= word_0;
            matrix_reg[row_index][1] <= word_1;
            matrix_reg[row_index][2] <= word_2;
            matrix_reg[row_index][3] <= word_3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            box_lo_a_reg[0] <= word_0;
            box_lo_a_reg[1] <= word_1;
            box_lo_a_reg[2] <= word_2;
            box_hi_a_reg[0] <= word_3;
            box_hi_a_reg[1] <= word_4;
            box_hi_a_reg[2] <= word_5;
        end
    end

    for (genvar r = 0; r < ROW_COUNT; r++)
    begin : g_row
        tbba_row_span #(
            .FRAC_BITS (FRAC_BITS)
        ) u_row_span (
            .clk        (clk),
            .ctl        (ctl),
            .coef       (matrix_reg[r]),
            .box_lo     (box_lo_a_reg),
            .box_hi     (box_hi_a_reg),
            .low_coord  (low_coord[r]),
            .high_coord (high_coord[r])
        );
    end

    always_comb
    begin
        have_point_next = have_point_reg;
        for (int i = 0; i < AXIS_COUNT; i++)
        begin
            bound_low_next[i]  = bound_low_reg[i];
            bound_high_next[i] = bound_high_reg[i];
        end
        case (op_c_reg)
            OP_CLEAR:
            begin
                have_point_next = 1'b0;
                for (int i = 0; i < AXIS_COUNT; i++)
                begin
                    bound_low_next[i]  = '0;
                    bound_high_next[i] = '0;
                end
            end
            OP_ADD:
            begin
                have_point_next = 1'b1;
                for (int i = 0; i < AXIS_COUNT; i++)
                begin
                    if (!have_point_reg || (low_coord[i] < bound_low_reg[i]))
                    begin
                        bound_low_next[i] = low_coord[i];
                    end
                    if (!have_point_reg || (high_coord[i] > bound_high_reg[i]))
                    begin
                        bound_high_next[i] = high_coord[i];
                    end
                end
            end
            default:
            begin
                have_point_next = have_point_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_point_reg <= 1'b0;
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                bound_low_reg[i]  <= '0;
                bound_high_reg[i] <= '0;
            end
        end
        else if (load_o)
        begin
            have_point_reg <= have_point_next;
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                bound_low_reg[i]  <= bound_low_next[i];
                bound_high_reg[i] <= bound_high_next[i];
            end
        end
    end

    assign result_valid = o_valid_reg;
    assign bounds_valid = have_point_reg;
    assign low_x        = bound_low_reg[0];
    assign low_y        = bound_low_reg[1];
    assign low_z        = bound_low_reg[2];
    assign high_x       = bound_high_reg[0];
    assign high_y       = bound_high_reg[1];
    assign high_z       = bound_high_reg[2];

endmodule
